/* sv/smpp_pkg.sv */
`default_nettype none

package smpp_pkg;

	localparam int FFT_POINTS_DFLT = 1024;
	localparam int PEAK_BINS_DFLT  = 512;

	localparam int BIN_W  = 32;
	localparam int HALF_W = 16;
	localparam int MAG_W  = 13;
	localparam int IDX_W  = 10;
	localparam int FREQ_W = 15;
	localparam int THR_W  = 13;

	// The power is scaled by 2^14 before the square root is taken.
	localparam int POW_W   = 32;
	localparam int SCALE_W = 14;
	localparam int RAD_W   = POW_W + SCALE_W;
	localparam int ROOT_W  = RAD_W / 2;

	localparam logic [MAG_W-1:0]  MAG_MAX    = 13'd8191;
	localparam logic [FREQ_W-1:0] FREQ_MAX   = 15'd32767;
	localparam logic [FREQ_W-1:0] FREQ_MUL   = 15'd20000;
	localparam int                FREQ_DIV   = 498;
	localparam logic [THR_W-1:0]  THR_RESET  = 13'd20;

	// Divisor selection of the shared serial divider.
	localparam logic DIV_SEL_MAG  = 1'b0;
	localparam logic DIV_SEL_FREQ = 1'b1;

	typedef struct packed {
		logic [BIN_W-1:0] packed_bin;
		logic             last_bin;
	} smpp_in_t;

	typedef struct packed {
		logic [MAG_W-1:0]  magnitude;
		logic [IDX_W-1:0]  bin_index;
		logic [FREQ_W-1:0] peak_frequency;
		logic              frame_done;
	} smpp_out_t;

	// Absolute value of a two's complement half word; the most negative code gives 32768.
	function automatic logic [HALF_W-1:0] abs16(input logic [HALF_W-1:0] x);
		logic [HALF_W-1:0] r;
		r = x[HALF_W-1] ? (~x + HALF_W'(1)) : x;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/smpp_isqrt.sv */
`default_nettype none

module smpp_isqrt
	import smpp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [POW_W-1:0]  power,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);

	localparam int REM_W = ROOT_W + 1;
	localparam int T_W   = REM_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [T_W-1:0] t;
	logic [T_W-1:0] trial;
	logic           ge;

	// Two radicand bits enter the partial remainder each cycle and one root bit is decided.
	assign t     = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = T_W'({root_q, 2'b01});
	assign ge    = (t >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {power, SCALE_W'(0)};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(t - trial) : REM_W'(t);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

/* sv/smpp_sdiv.sv */
`default_nettype none

module smpp_sdiv
	import smpp_pkg::*;
#(
	parameter int DW    = 24,
	parameter int RW    = 11,
	parameter int DIV_A = 1024,
	parameter int DIV_B = 498
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          sel,
	input  wire logic [DW-1:0] dividend,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    num_q;
	logic [RW-2:0]    rem_q;
	logic             sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RW-1:0] t;
	logic [RW-1:0] dv;
	logic          ge;

	// Restoring division: one dividend bit in, one quotient bit out per cycle.
	assign dv = (sel_q == DIV_SEL_FREQ) ? RW'(DIV_B) : RW'(DIV_A);
	assign t  = {rem_q, num_q[DW-1]};
	assign ge = (t >= dv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			sel_q <= sel;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= ge ? (RW-1)'(t - dv) : (RW-1)'(t);
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

`default_nettype wire

/* sv/spectrum_magnitude_peak_picker.sv */
// Spectrum magnitude and peak picker.
// Input channel (in_valid, in_stall, in_data): one FFT bin per request, in index order,
// with last_bin set on the final bin of a frame. Output channel (out_valid, out_stall,
// out_data): exactly one result per bin, carrying the bin's magnitude, its index and,
// on the last bin, the peak frequency of the frame with frame_done set.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the peak threshold;
// cfg_ready is always high and the register should only be written while idle.
// One bin is processed at a time. The work is a bit-serial square root (ROOT_W = 23
// steps) followed by a bit-serial division by FFT_POINTS (DW steps, 24 by default), and
// the bin's result is then registered; a new bin is taken only after that. The last bin
// of a frame whose peak reaches the threshold also needs a frequency division by
// FREQ_DIV on the same divider.
// A result waits in the output register while out_stall is high; the next bin is
// already accepted and processed, and only its final write waits for the register.
// Reset clears the bin counter and the peak search, empties the output register and sets
// the threshold to 20.
`default_nettype none

module spectrum_magnitude_peak_picker
	import smpp_pkg::*;
#(
	parameter int FFT_POINTS = FFT_POINTS_DFLT,
	parameter int PEAK_BINS  = PEAK_BINS_DFLT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire smpp_in_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output smpp_out_t             out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [THR_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(FFT_POINTS);
	localparam int BB_W  = $clog2(PEAK_BINS);
	localparam int FD_W  = BB_W + FREQ_W;
	localparam int DW    = (FD_W > ROOT_W) ? FD_W : ROOT_W;
	localparam int DMAX  = (FFT_POINTS > FREQ_DIV) ? FFT_POINTS : FREQ_DIV;
	localparam int RW    = $clog2(DMAX) + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQ_RE = 4'd1;
	localparam logic [3:0] S_SQ_IM = 4'd2;
	localparam logic [3:0] S_ROOT  = 4'd3;
	localparam logic [3:0] S_MAG   = 4'd4;
	localparam logic [3:0] S_PEAK  = 4'd5;
	localparam logic [3:0] S_FMUL  = 4'd6;
	localparam logic [3:0] S_FREQ  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0]        state_q;
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  best_mag_q;
	logic [BB_W-1:0]   best_bin_q;

	logic [HALF_W-1:0] re_q;
	logic [HALF_W-1:0] im_q;
	logic              last_q;
	logic [POW_W-1:0]  sq_q;
	logic [MAG_W-1:0]  mag_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FD_W-1:0]   fprod_q;
	logic [FREQ_W-1:0] freq_q;

	logic              out_valid_q;
	smpp_out_t         out_q;

	logic [POW_W-1:0]  power;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [ROOT_W-1:0] root;
	logic              div_start;
	logic              div_sel;
	logic [DW-1:0]     div_in;
	logic              div_done;
	logic [DW-1:0]     quot;

	logic              in_peak;
	logic              upd;
	logic [MAG_W-1:0]  nb_mag;
	logic [BB_W-1:0]   nb_bin;
	logic              slot_free;

	assign power      = sq_q + POW_W'(im_q) * POW_W'(im_q);
	assign sqrt_start = (state_q == S_SQ_IM);

	assign div_start = ((state_q == S_ROOT) && sqrt_done) || (state_q == S_FMUL);
	assign div_sel   = (state_q == S_FMUL) ? DIV_SEL_FREQ : DIV_SEL_MAG;
	assign div_in    = (state_q == S_FMUL) ? DW'(fprod_q) : DW'(root);

	// Bins 1 to PEAK_BINS-1 take part in the search; a tie keeps the earlier bin.
	assign in_peak = (cnt_q != '0) && (32'(cnt_q) < 32'(PEAK_BINS));
	assign upd     = in_peak && (mag_q > best_mag_q);
	assign nb_mag  = upd ? mag_q : best_mag_q;
	assign nb_bin  = upd ? BB_W'(cnt_q) : best_bin_q;

	assign slot_free = !out_valid_q || !out_stall;

	smpp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.power  (power),
		.done   (sqrt_done),
		.root   (root)
	);

	smpp_sdiv #(
		.DW    (DW),
		.RW    (RW),
		.DIV_A (FFT_POINTS),
		.DIV_B (FREQ_DIV)
	) u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sel      (div_sel),
		.dividend (div_in),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= THR_RESET;
			cnt_q       <= '0;
			best_mag_q  <= '0;
			best_bin_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if ((state_q == S_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SQ_RE;
					end
				end
				S_SQ_RE: state_q <= S_SQ_IM;
				S_SQ_IM: state_q <= S_ROOT;
				S_ROOT: begin
					if (sqrt_done) begin
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					if (div_done) begin
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					if (last_q) begin
						cnt_q      <= '0;
						best_mag_q <= '0;
						best_bin_q <= '0;
						state_q    <= (nb_mag >= thr_q) ? S_FMUL : S_OUT;
					end else begin
						cnt_q      <= (cnt_q == CNT_W'(FFT_POINTS - 1)) ?
							'0 : cnt_q + CNT_W'(1);
						best_mag_q <= nb_mag;
						best_bin_q <= nb_bin;
						state_q    <= S_OUT;
					end
				end
				S_FMUL: state_q <= S_FREQ;
				S_FREQ: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			re_q   <= abs16(in_data.packed_bin[HALF_W-1:0]);
			im_q   <= abs16(in_data.packed_bin[BIN_W-1:HALF_W]);
			last_q <= in_data.last_bin;
		end
		if (state_q == S_SQ_RE) begin
			sq_q <= POW_W'(re_q) * POW_W'(re_q);
		end
		if ((state_q == S_MAG) && div_done) begin
			mag_q <= (quot > DW'(MAG_MAX)) ? MAG_MAX : MAG_W'(quot);
		end
		if (state_q == S_PEAK) begin
			idx_q   <= IDX_W'(cnt_q);
			fprod_q <= FD_W'(nb_bin) * FD_W'(FREQ_MUL);
			freq_q  <= '0;
		end
		if ((state_q == S_FREQ) && div_done) begin
			freq_q <= (quot > DW'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(quot);
		end
		if ((state_q == S_OUT) && slot_free) begin
			out_q.magnitude      <= mag_q;
			out_q.bin_index      <= idx_q;
			out_q.peak_frequency <= freq_q;
			out_q.frame_done     <= last_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* tb/tb_spectrum_magnitude_peak_picker.sv */
`default_nettype none

module tb_spectrum_magnitude_peak_picker;
	timeunit 1ns;
	timeprecision 1ps;

	import smpp_pkg::*;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int WATCHDOG_LIMIT = 2000;

	// Tracks the frame state of the block and holds the results it should produce, oldest first.
	class peak_picker_model;
		logic [THR_W-1:0] threshold;
		int unsigned next_bin;
		int unsigned best_mag;
		int unsigned best_bin;
		smpp_out_t pending_results[$];
		int unsigned errors;

		function new();
			threshold = THR_RESET;
			next_bin = 0;
			best_mag = 0;
			best_bin = 0;
			errors = 0;
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned root;
			longint unsigned trial;
			int k;
			root = 0;
			for (k = 23; k >= 0; k--) begin
				trial = root | (64'd1 << k);
				if (trial * trial <= v)
					root = trial;
			end
			return root;
		endfunction

		function int unsigned half_abs(logic [HALF_W-1:0] h);
			return h[HALF_W-1] ? (32'h10000 - 32'(h)) : 32'(h);
		endfunction

		function void take_bin(smpp_in_t item);
			int unsigned re;
			int unsigned im;
			longint unsigned power;
			longint unsigned mag;
			longint unsigned freq;
			int unsigned idx;
			smpp_out_t res;
			re = half_abs(item.packed_bin[HALF_W-1:0]);
			im = half_abs(item.packed_bin[BIN_W-1:HALF_W]);
			power = longint'(re) * re + longint'(im) * im;
			mag = floor_root(power << SCALE_W) / FFT_POINTS_DFLT;
			if (mag > MAG_MAX)
				mag = MAG_MAX;
			idx = next_bin;
			freq = 0;
			// Only bins 1 to PEAK_BINS-1 compete, and a tie keeps the earlier bin.
			if (idx >= 1 && idx < PEAK_BINS_DFLT && mag > best_mag) begin
				best_mag = mag;
				best_bin = idx;
			end
			if (item.last_bin) begin
				if (best_mag >= threshold) begin
					freq = longint'(best_bin) * FREQ_MUL / FREQ_DIV;
					if (freq > FREQ_MAX)
						freq = FREQ_MAX;
				end
				next_bin = 0;
				best_mag = 0;
				best_bin = 0;
			end else begin
				next_bin = (idx + 1 >= FFT_POINTS_DFLT) ? 0 : idx + 1;
			end
			res.magnitude = mag[MAG_W-1:0];
			res.bin_index = idx[IDX_W-1:0];
			res.peak_frequency = freq[FREQ_W-1:0];
			res.frame_done = item.last_bin;
			pending_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(smpp_out_t got);
			smpp_out_t want;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, expected nothing, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("magnitude", want.magnitude, got.magnitude);
			compare_field("bin_index", want.bin_index, got.bin_index);
			compare_field("peak_frequency", want.peak_frequency, got.peak_frequency);
			compare_field("frame_done", want.frame_done, got.frame_done);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	smpp_in_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	smpp_out_t        out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [THR_W-1:0] cfg_data = '0;

	peak_picker_model book;
	bit burst_frame = 1'b0;
	int unsigned sent = 0;
	int quiet = 0;

	spectrum_magnitude_peak_picker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic send_bin(logic [BIN_W-1:0] value, bit last);
		smpp_in_t item;
		int gap;
		item.packed_bin = value;
		item.last_bin = last;
		gap = burst_frame ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		book.take_bin(item);
	endtask

	task automatic drain(int settle);
		in_valid <= 1'b0;
		while (book.pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] value);
		drain(8);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.threshold = value;
	endtask

	function automatic logic [HALF_W-1:0] random_half();
		int v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom_range(0, 65535);
			2: v = int'($urandom_range(0, 600)) - 300;
			3: begin
				case ($urandom_range(0, 4))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					3: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
			default: begin
				v = $urandom_range(0, 32767) >> $urandom_range(0, 15);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v[HALF_W-1:0];
	endfunction

	task automatic send_frame(int unsigned length);
		int unsigned k;
		burst_frame = ($urandom_range(0, 3) == 0);
		for (k = 0; k < length; k++) begin
			send_bin({random_half(), random_half()}, k == length - 1);
			sent++;
			// Now and then hold off until the block has returned every result.
			if ($urandom_range(0, 60) == 0)
				drain(0);
		end
		burst_frame = 1'b0;
	endtask

	initial begin : result_sink
		int gap;
		int seen;
		int calm;
		calm = 0;
		@(posedge arst_n);
		forever begin
			if (calm > 0) begin
				gap = 0;
				calm--;
			end else if ($urandom_range(0, 7) == 0) begin
				calm = $urandom_range(10, 40);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 10);
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				seen = 0;
				while (seen < gap) begin
					@(posedge clk);
					if (out_valid)
						seen++;
				end
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			book.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("** spectrum_magnitude_peak_picker: FAILED **");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned frame_no;
		int unsigned next_phase;
		logic [THR_W-1:0] thr;
		book = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale extremes; bin 0 is outside the search and the tie at the end keeps bin 1.
		send_bin(32'h8000_8000, 1'b0);
		send_bin(32'h7FFF_7FFF, 1'b0);
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b0);
		send_bin(32'h8000_0000, 1'b0);
		send_bin(32'h0000_8000, 1'b0);
		send_bin(32'h7FFF_7FFF, 1'b1);
		// A frame of one bin never has a bin above zero.
		send_bin(32'h8000_8000, 1'b1);
		// Peak of 19 falls just below the reset threshold.
		send_bin(32'h0000_0098, 1'b0);
		send_bin(32'h0098_0000, 1'b0);
		send_bin(32'hFF68_0000, 1'b1);
		// Peak of exactly 20 passes it.
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'h0000_00A0, 1'b0);
		send_bin(32'h0000_FF60, 1'b0);
		send_bin(32'h0001_0001, 1'b1);

		write_threshold('0);
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'h0000_0000, 1'b1);
		write_threshold(13'd8191);
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'h8000_8000, 1'b1);
		write_threshold(13'd5792);
		send_bin(32'h0000_0000, 1'b0);
		send_bin(32'h8000_8000, 1'b1);
		write_threshold(THR_RESET);

		frame_no = 0;
		next_phase = 200;
		while (sent < RANDOM_ITEMS) begin
			// One frame runs past FFT_POINTS so that the bin counter wraps.
			if (frame_no == 2)
				send_frame(FFT_POINTS_DFLT + 6);
			else
				send_frame($urandom_range(1, 40));
			frame_no++;
			if (sent >= next_phase) begin
				case ($urandom_range(0, 5))
					0: thr = '0;
					1: thr = 13'd8191;
					2: thr = THR_W'($urandom_range(1, 60));
					3: thr = THR_W'($urandom_range(0, 8191));
					4: thr = THR_W'($urandom_range(2000, 5000));
					default: thr = THR_RESET;
				endcase
				write_threshold(thr);
				next_phase = sent + 200;
			end
		end

		drain(100);
		if (book.errors == 0 && book.pending_results.size() == 0) begin
			$display("** spectrum_magnitude_peak_picker: PASSED **");
		end else begin
			$display("** spectrum_magnitude_peak_picker: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
